// ===== rtl/core/gbp_pkg.sv =====
// Shared constants for the gshare branch predictor: parameter defaults,
// RISC-V branch decode codes and the counter reset value.
// No dependencies.
`default_nettype none

package gbp_pkg;

    // Default geometry. BLOCK_BYTES must be a power of two.
    localparam int unsigned HISTORY_BITS_DEF = 8;
    localparam int unsigned BLOCK_BYTES_DEF  = 16;

    // Width of the index and history result fields.
    localparam int unsigned OUT_W = 8;

    // 32-bit conditional branch: major opcode, and the two funct3 codes that
    // are not branches.
    localparam logic [6:0]  OPC_BRANCH = 7'h63;
    localparam logic [2:0]  F3_RSVD_A  = 3'd2;
    localparam logic [2:0]  F3_RSVD_B  = 3'd3;

    // Compressed C.BEQZ and C.BNEZ match under this mask.
    localparam logic [15:0] C_BR_MASK  = 16'he003;
    localparam logic [15:0] C_BEQZ     = 16'hc001;
    localparam logic [15:0] C_BNEZ     = 16'he001;

    // Instruction sizes in bytes.
    localparam logic [63:0] SIZE_RV    = 64'd4;
    localparam logic [63:0] SIZE_RVC   = 64'd2;

    // Two-bit saturating counter codes.
    localparam logic [1:0]  CTR_MAX    = 2'd3;
    localparam logic [1:0]  CTR_MIN    = 2'd0;
    localparam logic [1:0]  CTR_INIT   = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/gbp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read during a write to the same address returns the old contents.
// No dependencies.
`default_nettype none

module gbp_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/gshare_branch_predictor.sv =====
// gshare branch predictor with 2-bit saturating counters, one row of counters
// per hashed index. Depends on gbp_pkg and gbp_ram.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+-----------------------------------------
//  in      | in  | i_in_valid / o_in_ready   | i_pc, i_next_pc, i_insn
//  out     | out | o_out_valid / i_out_ready | o_is_cond_branch .. o_history_out (six)
//
// One item per cycle while the output is not stalled; each result passes the counter
// RAM read, then the update stage and output register.
// After reset the counter RAM is cleared to weakly taken, one row per cycle,
// all 2**HISTORY_BITS rows (256 at the defaults), with o_in_ready low.
// A stalled output holds the pipeline; a back-to-back branch to the same row
// reads the counters through a one-entry bypass of the last write.
`default_nettype none

module gshare_branch_predictor #(
    parameter int unsigned HISTORY_BITS = gbp_pkg::HISTORY_BITS_DEF,
    parameter int unsigned BLOCK_BYTES  = gbp_pkg::BLOCK_BYTES_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,

    input  wire                       i_in_valid,
    output logic                      o_in_ready,
    input  wire  [63:0]               i_pc,
    input  wire  [63:0]               i_next_pc,
    input  wire  [31:0]               i_insn,

    output logic                      o_out_valid,
    input  wire                       i_out_ready,
    output logic                      o_is_cond_branch,
    output logic                      o_predicted_taken,
    output logic                      o_actual_taken,
    output logic                      o_mispredict,
    output logic [gbp_pkg::OUT_W-1:0] o_table_index,
    output logic [gbp_pkg::OUT_W-1:0] o_history_out
);

    localparam int unsigned HB        = HISTORY_BITS;
    localparam int unsigned BLK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int unsigned EPR       = BLOCK_BYTES / 2;
    localparam int unsigned SUB_W     = BLK_SHIFT - 1;
    localparam int unsigned ROW_W     = 2 * EPR;
    localparam int unsigned ROWS      = 1 << HB;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [HB-1:0]    r_hist;
    logic             r_clr_active;
    logic [HB-1:0]    r_clr_row;

    logic             r_s1_valid;
    logic             r_s1_br;
    logic             r_s1_taken;
    logic [HB-1:0]    r_s1_row;
    logic [SUB_W-1:0] r_s1_sub;
    logic [HB-1:0]    r_s1_hist;

    logic             r_byp_valid;
    logic [HB-1:0]    r_byp_row;
    logic [ROW_W-1:0] r_byp_data;

    logic             r_out_valid;
    logic             r_out_br;
    logic             r_out_pred;
    logic             r_out_taken;
    logic [HB-1:0]    r_out_row;
    logic [HB-1:0]    r_out_hist;

    // ------------------------------------------------------------------
    // Input stage: decode, outcome, hash and history.
    // ------------------------------------------------------------------
    logic            in_acc;
    logic            adv;
    logic [2:0]      f3;
    logic            is_rv_br;
    logic            is_rvc_br;
    logic            is_br;
    logic [63:0]     fall_thru;
    logic            taken;
    logic [HB-1:0]   row;
    logic [SUB_W-1:0] sub;
    logic [HB:0]     hist_shift;

    assign f3        = i_insn[14:12];
    assign is_rv_br  = (i_insn[6:0] == gbp_pkg::OPC_BRANCH)
                    && (f3 != gbp_pkg::F3_RSVD_A) && (f3 != gbp_pkg::F3_RSVD_B);
    assign is_rvc_br = ((i_insn[15:0] & gbp_pkg::C_BR_MASK) == gbp_pkg::C_BEQZ)
                    || ((i_insn[15:0] & gbp_pkg::C_BR_MASK) == gbp_pkg::C_BNEZ);
    assign is_br     = is_rv_br || is_rvc_br;
    assign fall_thru = i_pc + (is_rv_br ? gbp_pkg::SIZE_RV : gbp_pkg::SIZE_RVC);
    assign taken     = is_br && (i_next_pc != fall_thru);

    // Row is ((pc >> 1) / BLOCK_BYTES) ^ history; sub-entry is (pc % BLOCK_BYTES) >> 1.
    assign row        = i_pc[BLK_SHIFT+1 +: HB] ^ r_hist;
    assign sub        = i_pc[BLK_SHIFT-1:1];
    assign hist_shift = {r_hist, taken};

    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_clr_active && (!r_s1_valid || adv);
    assign in_acc     = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Counter RAM: one row of EPR counters per word.
    // ------------------------------------------------------------------
    logic             ram_we;
    logic [HB-1:0]    ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;
    logic             upd_we;

    gbp_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_ctr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc && is_br),
        .i_raddr (row),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Update stage: pick the counter, predict, saturate, write the row back.
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] row_data;
    logic [1:0]       ctr;
    logic [1:0]       ctr_upd;
    logic [ROW_W-1:0] row_upd;

    // The RAM returns old data when the previous branch wrote this row at the
    // same edge that this item was read; the bypass holds that last write.
    assign row_data = (r_byp_valid && (r_byp_row == r_s1_row)) ? r_byp_data : ram_rdata;
    assign ctr      = row_data[{r_s1_sub, 1'b0} +: 2];

    always_comb begin
        if (r_s1_taken) begin
            ctr_upd = (ctr == gbp_pkg::CTR_MAX) ? ctr : ctr + 2'd1;
        end else begin
            ctr_upd = (ctr == gbp_pkg::CTR_MIN) ? ctr : ctr - 2'd1;
        end
    end

    always_comb begin
        row_upd = row_data;
        for (int k = 0; k < EPR; k++) begin
            if (r_s1_sub == SUB_W'(k)) begin
                row_upd[2*k +: 2] = ctr_upd;
            end
        end
    end

    assign upd_we    = r_s1_valid && r_s1_br && adv;
    assign ram_we    = r_clr_active || upd_we;
    assign ram_waddr = r_clr_active ? r_clr_row : r_s1_row;
    assign ram_wdata = r_clr_active ? {EPR{gbp_pkg::CTR_INIT}} : row_upd;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist       <= '0;
            r_clr_active <= 1'b1;
            r_clr_row    <= '0;
            r_s1_valid   <= 1'b0;
            r_byp_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_clr_active) begin
                r_clr_row <= r_clr_row + 1'b1;
                if (r_clr_row == {HB{1'b1}}) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (in_acc && is_br) begin
                r_hist <= hist_shift[HB-1:0];
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (upd_we) begin
                r_byp_valid <= 1'b1;
            end
            if (adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_br    <= is_br;
            r_s1_taken <= taken;
            r_s1_row   <= row;
            r_s1_sub   <= sub;
            r_s1_hist  <= hist_shift[HB-1:0];
        end
        if (upd_we) begin
            r_byp_row  <= r_s1_row;
            r_byp_data <= row_upd;
        end
        if (adv && r_s1_valid) begin
            r_out_br    <= r_s1_br;
            r_out_pred  <= r_s1_br && ctr[1];
            r_out_taken <= r_s1_br && r_s1_taken;
            r_out_row   <= r_s1_br ? r_s1_row : '0;
            r_out_hist  <= r_s1_br ? r_s1_hist : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_is_cond_branch  = r_out_br;
    assign o_predicted_taken = r_out_pred;
    assign o_actual_taken    = r_out_taken;
    assign o_mispredict      = r_out_pred ^ r_out_taken;
    assign o_table_index     = gbp_pkg::OUT_W'(r_out_row);
    assign o_history_out     = gbp_pkg::OUT_W'(r_out_hist);

endmodule

`default_nettype wire
